// ===== hdl/crcrx_pkg.sv =====
// Shared constants, types and the byte-wide CRC-16 update for the reply receiver.
// Used by the frame assembler and the top level.
package crcrx_pkg;

   // Item operation codes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_IDLE = 1'b1;

   // CRC-16, reflected polynomial, LSB first
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Function codes of interest
   localparam logic [7:0] CODE_MULTI  = 8'h13;
   localparam logic [7:0] CODE_SINGLE = 8'h15;

   // Frame layout
   localparam int BODY_LEN   = 8;
   localparam int BODY_AW    = $clog2(BODY_LEN);
   localparam int DATA_START = 4;
   localparam int IDX_ID     = 0;
   localparam int IDX_IO     = 1;
   localparam int IDX_FUNC   = 3;

   typedef logic [3:0] pos_type;
   localparam pos_type POS_CRC_HI = 4'd8;
   localparam pos_type POS_CRC_LO = 4'd9;

   // Status codes
   localparam logic [1:0] STATUS_MULTI  = 2'd0;
   localparam logic [1:0] STATUS_SINGLE = 2'd1;
   localparam logic [1:0] STATUS_OTHER  = 2'd2;
   localparam logic [1:0] STATUS_BADCRC = 2'd3;

   typedef struct packed {
      logic [7:0]         motor_id;
      logic [7:0]         io_byte;
      logic [7:0]         func_code;
      logic signed [31:0] position_count;
      logic [1:0]         status;
   } result_type;

   // One byte through the CRC register, eight shift steps
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== hdl/crcrx_if.sv =====
// Handshake channels of the reply receiver: byte items in, decoded frames out.
// No package dependency; the widths are fixed here.
interface crcrx_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;

   modport source (output valid, output op, output rx_byte, input ready);
   modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface crcrx_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         motor_id;
   logic [7:0]         io_byte;
   logic [7:0]         func_code;
   logic signed [31:0] position_count;
   logic [1:0]         status;

   modport source (output valid, output motor_id, output io_byte, output func_code,
                   output position_count, output status, input ready);
   modport sink   (input valid, input motor_id, input io_byte, input func_code,
                   input position_count, input status, output ready);
endinterface

// ===== hdl/crcrx_framer.sv =====
// Frame assembler: byte position, stored body bytes, running CRC and the check.
// Depends on crcrx_pkg.
module crcrx_framer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 step_op,
   input  logic [7:0]           step_byte,
   output logic                 done,
   output crcrx_pkg::result_type result
);

   crcrx_pkg::pos_type pos_ff, pos_in, pos_cur;
   logic [15:0]        crc_ff, crc_in;
   logic [7:0]         body_ff [crcrx_pkg::BODY_LEN];
   logic [7:0]         crc_hi_ff;
   logic               crc_good;
   logic [7:0]         code;

   // Out-of-range position counts as a frame start
   assign pos_cur = (pos_ff > crcrx_pkg::POS_CRC_LO) ? '0 : pos_ff;

   assign done = step && (step_op == crcrx_pkg::OP_BYTE)
              && (pos_cur == crcrx_pkg::POS_CRC_LO);

   // Position and CRC next values
   always_comb begin
      pos_in = pos_ff;
      crc_in = crc_ff;
      if (step) begin
         if (step_op == crcrx_pkg::OP_IDLE || pos_cur == crcrx_pkg::POS_CRC_LO) begin
            pos_in = '0;
            crc_in = crcrx_pkg::CRC_INIT;
         end else begin
            pos_in = pos_cur + 4'd1;
            if (pos_cur < crcrx_pkg::POS_CRC_HI) begin
               crc_in = crcrx_pkg::crc_byte(crc_ff, step_byte);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         crc_ff <= crcrx_pkg::CRC_INIT;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
      end
   end

   // Frame byte storage, no reset
   always_ff @(posedge clock) begin
      if (step && step_op == crcrx_pkg::OP_BYTE) begin
         if (pos_cur < crcrx_pkg::POS_CRC_HI) begin
            body_ff[pos_cur[crcrx_pkg::BODY_AW-1:0]] <= step_byte;
         end
         if (pos_cur == crcrx_pkg::POS_CRC_HI) begin
            crc_hi_ff <= step_byte;
         end
      end
   end

   // Check and decode on the CRC low byte
   assign crc_good = (crc_ff == {crc_hi_ff, step_byte});
   assign code     = body_ff[crcrx_pkg::IDX_FUNC];

   always_comb begin
      result.motor_id       = body_ff[crcrx_pkg::IDX_ID];
      result.io_byte        = body_ff[crcrx_pkg::IDX_IO];
      result.func_code      = code;
      result.position_count = signed'({body_ff[crcrx_pkg::DATA_START],
                                       body_ff[crcrx_pkg::DATA_START + 1],
                                       body_ff[crcrx_pkg::DATA_START + 2],
                                       body_ff[crcrx_pkg::DATA_START + 3]});
      if (!crc_good) begin
         result.status = crcrx_pkg::STATUS_BADCRC;
      end else if (code == crcrx_pkg::CODE_MULTI) begin
         result.status = crcrx_pkg::STATUS_MULTI;
      end else if (code == crcrx_pkg::CODE_SINGLE) begin
         result.status = crcrx_pkg::STATUS_SINGLE;
      end else begin
         result.status = crcrx_pkg::STATUS_OTHER;
      end
   end

endmodule

// ===== hdl/crc16_checked_reply_receiver_unit.sv =====
// CRC-16 checked reply receiver: top level with input and result registers.
// Depends on crcrx_pkg, crcrx_if and crcrx_framer.
//
// Usage:
//   req_if carries one item per handshake: op 0 with a received byte, or op 1
//   when the line goes idle, which drops any partial frame. Every 10th byte of
//   a frame (id, I/O, two function bytes, four big-endian data bytes, CRC high,
//   CRC low) produces one item on rsp_if with id, I/O byte, function code,
//   signed position count and status (multi-turn, single-turn, other, or CRC
//   mismatch). Other items produce nothing.
//   Throughput: one item per cycle while no result waits on rsp_if.ready; the
//   CRC update is a byte-wide step of the framer between the input register
//   and the result register. Path: an accepted item is held in the input
//   register, then its result is taken into the result register on rsp_if.
//   Reset: synchronous, active high; empties both registers and starts a new
//   frame with the CRC at its initial value.
//   Stall: while a result waits, the input register still takes one more
//   item; req_if.ready then drops until rsp_if.ready frees the result.
module crc16_checked_reply_receiver_unit (
   input  logic         clock,
   input  logic         reset,
   crcrx_req_if.sink    req_if,
   crcrx_rsp_if.source  rsp_if
);

   logic                  in_valid_ff;
   logic                  in_op_ff;
   logic [7:0]            in_byte_ff;
   logic                  out_valid_ff;
   crcrx_pkg::result_type out_ff;
   crcrx_pkg::result_type result;
   logic                  advance;
   logic                  accept;
   logic                  done;

   // Handshake
   assign advance       = !out_valid_ff || rsp_if.ready;
   assign req_if.ready  = !in_valid_ff || advance;
   assign accept        = req_if.valid && req_if.ready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff   <= req_if.op;
         in_byte_ff <= req_if.rx_byte;
      end
   end

   crcrx_framer u_framer (
      .clock     (clock),
      .reset     (reset),
      .step      (in_valid_ff && advance),
      .step_op   (in_op_ff),
      .step_byte (in_byte_ff),
      .done      (done),
      .result    (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= done;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && done) begin
         out_ff <= result;
      end
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.motor_id       = out_ff.motor_id;
   assign rsp_if.io_byte        = out_ff.io_byte;
   assign rsp_if.func_code      = out_ff.func_code;
   assign rsp_if.position_count = out_ff.position_count;
   assign rsp_if.status         = out_ff.status;

endmodule
